// ===== rtl/sfp_pkg.sv =====
// sfp_pkg: shared field widths and request codes for the shelf packer.
// No dependencies.
`timescale 1ns / 1ps

package sfp_pkg;

  localparam int FIELD_W = 12;

  localparam logic MODE_PLACE = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

endpackage

// ===== rtl/shelf_rectangle_packer_core.sv =====
// Shelf rectangle packer top level: request sequencer, shelf height and fill memories.
// Depends on sfp_pkg, sfp_ram, sfp_fit.
`timescale 1ns / 1ps

// First-fit shelf packer for a square atlas. A place request walks the open
// shelves top to bottom, one shelf per cycle through the shelf memories
// (registered reads), and lands on the first shelf tall enough with room
// left; otherwise it opens a new shelf below the others if the atlas height,
// the atlas width and the shelf count allow. A clear request empties the
// table in one pass through the sequencer. The shelf scan sets the rate. A
// new request is taken as soon as the previous result is in the output
// register.

module shelf_rectangle_packer_core #(
  parameter int ATLAS_SIZE  = 2048,
  parameter int MAX_SHELVES = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        mode,
  input  logic [sfp_pkg::FIELD_W-1:0] rect_width,
  input  logic [sfp_pkg::FIELD_W-1:0] rect_height,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        placed,
  output logic [sfp_pkg::FIELD_W-1:0] pos_x,
  output logic [sfp_pkg::FIELD_W-1:0] pos_y
);

  import sfp_pkg::*;

  localparam int AW = $clog2(ATLAS_SIZE + 1);
  localparam int IW = $clog2(MAX_SHELVES);
  localparam int CW = $clog2(MAX_SHELVES + 1);
  localparam int SW = ((AW > FIELD_W) ? AW : FIELD_W) + 1;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t               state;
  logic                 req_mode;
  logic [FIELD_W-1:0]   req_w;
  logic [FIELD_W-1:0]   req_h;
  logic [IW-1:0]        chk_idx;
  logic [AW-1:0]        top;
  logic                 hit;
  logic [AW-1:0]        hit_x;
  logic [AW-1:0]        hit_y;
  logic [AW-1:0]        hit_fill;
  logic [CW-1:0]        shelf_count;
  logic [AW-1:0]        stacked;

  logic                 accept;
  logic                 out_free;
  logic                 commit;
  logic                 is_clear;
  logic                 last_shelf;
  logic                 new_ok;
  logic [IW-1:0]        raddr;
  logic [IW-1:0]        waddr;
  logic                 fill_we;
  logic                 height_we;
  logic [AW-1:0]        fill_wdata;
  logic [AW-1:0]        rd_height;
  logic [AW-1:0]        rd_fill;
  logic                 fit;
  logic [AW-1:0]        fill_sum;

  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign commit     = (state == S_DONE) && out_free;
  assign is_clear   = (req_mode == MODE_CLEAR);
  assign last_shelf = (CW'(chk_idx) + CW'(1)) == shelf_count;

  assign new_ok = (shelf_count < CW'(MAX_SHELVES))
               && (SW'(req_w) <= SW'(ATLAS_SIZE))
               && ((SW'(stacked) + SW'(req_h)) <= SW'(ATLAS_SIZE));

  // Next shelf to read: the first on acceptance, else the one after the shelf being checked
  assign raddr      = (state == S_IDLE) ? '0 : chk_idx + IW'(1);
  assign waddr      = hit ? chk_idx : shelf_count[IW-1:0];
  assign fill_wdata = hit ? hit_fill : AW'(req_w);
  assign fill_we    = commit && !is_clear && (hit || new_ok);
  assign height_we  = commit && !is_clear && !hit && new_ok;

  sfp_ram #(
    .WIDTH(AW),
    .DEPTH(MAX_SHELVES)
  ) u_height_ram (
    .clk  (clk),
    .we   (height_we),
    .waddr(waddr),
    .wdata(AW'(req_h)),
    .raddr(raddr),
    .rdata(rd_height)
  );

  sfp_ram #(
    .WIDTH(AW),
    .DEPTH(MAX_SHELVES)
  ) u_fill_ram (
    .clk  (clk),
    .we   (fill_we),
    .waddr(waddr),
    .wdata(fill_wdata),
    .raddr(raddr),
    .rdata(rd_fill)
  );

  sfp_fit #(
    .ATLAS_SIZE(ATLAS_SIZE),
    .AW        (AW)
  ) u_fit (
    .shelf_h (rd_height),
    .shelf_f (rd_fill),
    .w       (req_w),
    .h       (req_h),
    .fit     (fit),
    .fill_sum(fill_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      shelf_count <= '0;
      stacked     <= '0;
      out_valid   <= 1'b0;
      hit         <= 1'b0;
    end else begin
      if (commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req_mode <= mode;
            req_w    <= rect_width;
            req_h    <= rect_height;
            chk_idx  <= '0;
            top      <= '0;
            hit      <= 1'b0;
            if (mode == MODE_CLEAR || shelf_count == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (fit) begin
            hit      <= 1'b1;
            hit_x    <= rd_fill;
            hit_y    <= top;
            hit_fill <= fill_sum;
            state    <= S_DONE;
          end else begin
            top <= top + rd_height;
            if (last_shelf) begin
              state <= S_DONE;
            end else begin
              chk_idx <= chk_idx + IW'(1);
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
            if (is_clear) begin
              shelf_count <= '0;
              stacked     <= '0;
              placed      <= 1'b0;
              pos_x       <= '0;
              pos_y       <= '0;
            end else if (hit) begin
              placed <= 1'b1;
              pos_x  <= FIELD_W'(hit_x);
              pos_y  <= FIELD_W'(hit_y);
            end else if (new_ok) begin
              shelf_count <= shelf_count + CW'(1);
              stacked     <= stacked + AW'(req_h);
              placed      <= 1'b1;
              pos_x       <= '0;
              pos_y       <= FIELD_W'(stacked);
            end else begin
              placed <= 1'b0;
              pos_x  <= '0;
              pos_y  <= '0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/sfp_ram.sv =====
// sfp_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module sfp_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sfp_fit.sv =====
// sfp_fit: checks whether a rectangle fits on one shelf and gives the new fill.
// Depends on sfp_pkg.
`timescale 1ns / 1ps

module sfp_fit #(
  parameter int ATLAS_SIZE = 2048,
  parameter int AW         = 12
) (
  input  logic [AW-1:0]               shelf_h,
  input  logic [AW-1:0]               shelf_f,
  input  logic [sfp_pkg::FIELD_W-1:0] w,
  input  logic [sfp_pkg::FIELD_W-1:0] h,
  output logic                        fit,
  output logic [AW-1:0]               fill_sum
);

  import sfp_pkg::*;

  localparam int SW = ((AW > FIELD_W) ? AW : FIELD_W) + 1;

  logic [SW-1:0] sum;

  assign sum      = SW'(shelf_f) + SW'(w);
  assign fit      = (SW'(shelf_h) >= SW'(h)) && (sum <= SW'(ATLAS_SIZE));
  assign fill_sum = AW'(sum);

endmodule
